@@ rtl/adcal_pkg.sv @@
// shared types, constants and helpers for the adc average / deadband / calibrate block
// no dependencies
package adcal_pkg;

  localparam int unsigned RUN_LENGTH = 16;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned SUM_W = $clog2(255 * RUN_LENGTH + 1);
  localparam int unsigned CNT_W = $clog2(RUN_LENGTH);
  localparam int unsigned DIV_W = DATA_W;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned DVD_W = PROD_W;
  localparam int unsigned STEP_W = $clog2(DVD_W);
  localparam int unsigned SEG_W = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0] LOW_LIMIT_RST = 8'h1A;
  localparam logic [DATA_W-1:0] HIGH_LIMIT_RST = 8'hC0;
  localparam logic [DATA_W-1:0] DEADBAND_RST = 8'd2;
  localparam logic [DATA_W-1:0] FULL_SCALE = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 2'd0,
    CFG_HIGH_LIMIT = 2'd1,
    CFG_DEADBAND   = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_CAL,
    ST_CAL_WAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  localparam logic [SEG_W-1:0] SEG_TABLE [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    return SEG_TABLE[digit];
  endfunction

endpackage

@@ rtl/adcal_in_if.sv @@
// input channel: one converter sample word with its compare value
// depends on adcal_pkg
interface adcal_in_if;
  logic                          valid;
  logic                          ready;
  logic [adcal_pkg::DATA_W-1:0]  sample;
  logic [adcal_pkg::DATA_W-1:0]  compare_value;

  modport source (output valid, output sample, output compare_value, input ready);
  modport sink (input valid, input sample, input compare_value, output ready);
endinterface

@@ rtl/adcal_out_if.sv @@
// output channel: one calibrated result word per run
// depends on adcal_pkg
interface adcal_out_if;
  logic                          valid;
  logic                          ready;
  logic [adcal_pkg::DATA_W-1:0]  level;
  logic [adcal_pkg::DATA_W-1:0]  held_level;
  logic [adcal_pkg::SEG_W-1:0]   high_segments;
  logic [adcal_pkg::SEG_W-1:0]   low_segments;
  logic                          match;

  modport source (output valid, output level, output held_level, output high_segments,
                  output low_segments, output match, input ready);
  modport sink (input valid, input level, input held_level, input high_segments,
                input low_segments, input match, output ready);
endinterface

@@ rtl/adcal_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on adcal_pkg
module adcal_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  adcal_pkg::div_req_t req_i,
  output adcal_pkg::div_rsp_t rsp_o
);
  import adcal_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DIV_W-1:0]  dsr_q, dsr_d;
  logic [DIV_W:0]    rem_sh;
  logic              ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, dsr_q};
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DVD_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? DIV_W'(rem_sh - {1'b0, dsr_q}) : DIV_W'(rem_sh);
      quo_d = {quo_q[DVD_W-2:0], ge};
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/adc_average_deadband_calibrate_unit.sv @@
// top level: run accumulator, deadband hold, calibration sequencer, output register
// depends on adcal_pkg, adcal_in_if, adcal_out_if, adcal_div
// a sample that does not end a run is taken while ready stays high
// a run-ending sample holds ready low through average, calibrate, a wait on the shared
//   bit-serial divider, and finish; the wait is skipped when the level clamps to 0 or 255
// the result word shows with ready's return; a stalled word delays the next run end
// reset: limits 26 / 192, deadband 2, sum, count and held average cleared
module adc_average_deadband_calibrate_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  adcal_in_if.sink                        in_if,
  adcal_out_if.source                     out_if,
  input  logic                            cfg_we_i,
  input  logic [adcal_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adcal_pkg::DATA_W-1:0]    cfg_data_i
);
  import adcal_pkg::*;

  state_e            state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d, sum_add;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DATA_W-1:0] held_q, held_d;
  logic [DATA_W-1:0] cmp_q, cmp_d;
  logic [DATA_W-1:0] lvl_q, lvl_d;
  logic [DATA_W-1:0] low_q, high_q, band_q;
  logic [DATA_W-1:0] avg, quo, diff, span;
  logic [PROD_W-1:0] prod;
  logic              out_load;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_level_q, out_held_q;
  logic [SEG_W-1:0]  out_hseg_q, out_lseg_q;
  logic              out_match_q;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  adcal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_LIMIT_RST;
      high_q <= HIGH_LIMIT_RST;
      band_q <= DEADBAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_LIMIT:  low_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: high_q <= cfg_data_i;
        CFG_DEADBAND:   band_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_add = sum_q + SUM_W'(in_if.sample);
    avg     = DATA_W'(sum_q / RUN_LENGTH);
    quo     = div_rsp.quotient[DATA_W-1:0];
    diff    = (avg >= held_q) ? avg - held_q : held_q - avg;
    span    = held_q - low_q;
    prod    = {span, DATA_W'(0)} - PROD_W'(span);
  end

  always_comb begin
    state_d          = state_q;
    sum_d            = sum_q;
    cnt_d            = cnt_q;
    held_d           = held_q;
    cmp_d            = cmp_q;
    lvl_d            = lvl_q;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    in_if.ready      = (state_q == ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          sum_d = sum_add;
          cmp_d = in_if.compare_value;
          if (cnt_q == CNT_W'(RUN_LENGTH - 1)) begin
            cnt_d   = '0;
            state_d = ST_AVG;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_AVG: begin
        sum_d = '0;
        if (diff > band_q) held_d = avg;
        state_d = ST_CAL;
      end
      ST_CAL: begin
        if (held_q <= low_q) begin
          lvl_d   = '0;
          state_d = ST_FIN;
        end else if (held_q >= high_q) begin
          lvl_d   = FULL_SCALE;
          state_d = ST_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(prod);
          div_req.divisor  = DIV_W'(high_q - low_q);
          state_d          = ST_CAL_WAIT;
        end
      end
      ST_CAL_WAIT: begin
        if (div_rsp.done) begin
          lvl_d   = quo;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_if.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_load | (out_valid_q & ~out_if.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q <= cmp_d;
    lvl_q <= lvl_d;
    if (out_load) begin
      out_level_q <= lvl_q;
      out_held_q  <= held_q;
      out_hseg_q  <= seg_of(lvl_q[7:4]);
      out_lseg_q  <= seg_of(lvl_q[3:0]);
      out_match_q <= (lvl_q == cmp_q);
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.level         = out_level_q;
  assign out_if.held_level    = out_held_q;
  assign out_if.high_segments = out_hseg_q;
  assign out_if.low_segments  = out_lseg_q;
  assign out_if.match         = out_match_q;

endmodule

@@ rtl/adcal_chk.sv @@
// port-level checks on the result channel, bound to the top level
// depends on adcal_pkg and adc_average_deadband_calibrate_unit
module adcal_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [adcal_pkg::DATA_W-1:0]    out_level,
  input logic [adcal_pkg::DATA_W-1:0]    out_held,
  input logic [adcal_pkg::SEG_W-1:0]     out_hseg,
  input logic [adcal_pkg::SEG_W-1:0]     out_lseg
);
  import adcal_pkg::*;

  // no word shown once reset has been seen
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid)
    else $error("result valid during reset");

  // stalled word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_level) && $stable(out_held))
    else $error("stalled result changed");

  // zero level shows zero on both digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_level == '0 |-> out_hseg == SEG_TABLE[0] && out_lseg == SEG_TABLE[0])
    else $error("segment codes wrong for zero level");

  // full scale shows F on both digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_level == FULL_SCALE |-> out_hseg == SEG_TABLE[15] &&
    out_lseg == SEG_TABLE[15])
    else $error("segment codes wrong for full scale");

endmodule

bind adc_average_deadband_calibrate_unit adcal_chk u_adcal_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_level (out_if.level),
  .out_held  (out_if.held_level),
  .out_hseg  (out_if.high_segments),
  .out_lseg  (out_if.low_segments)
);

@@ tb/adcal_level_checker.sv @@
// checker for the adc average / deadband / calibrate unit: predicts one result word per run
// and compares it field by field; depends on adcal_pkg, adcal_in_if, adcal_out_if
`timescale 1ns / 1ps

module adcal_level_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  adcal_in_if                             in_mon,
  adcal_out_if                            out_mon,
  input  logic                            cfg_we_i,
  input  logic [adcal_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [adcal_pkg::DATA_W-1:0]    cfg_data_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import adcal_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] level;
    logic [DATA_W-1:0] held;
    logic [SEG_W-1:0]  high_segs;
    logic [SEG_W-1:0]  low_segs;
    logic              match;
  } level_word_t;

  localparam logic [SEG_W-1:0] DIGIT_SEGS [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71
  };

  logic [DATA_W-1:0] low_lim;
  logic [DATA_W-1:0] high_lim;
  logic [DATA_W-1:0] dead_band;
  logic [SUM_W-1:0]  run_sum;
  logic [CNT_W-1:0]  run_cnt;
  logic [DATA_W-1:0] held_avg;
  level_word_t       level_words_q [$];
  int                fails;

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned sum_next;
    int unsigned avg;
    int unsigned gap;
    int unsigned lvl;
    level_word_t want;
    if (!rst_ni) begin
      low_lim = LOW_LIMIT_RST;
      high_lim = HIGH_LIMIT_RST;
      dead_band = DEADBAND_RST;
      run_sum = '0;
      run_cnt = '0;
      held_avg = '0;
      level_words_q.delete();
      fails = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOW_LIMIT: low_lim = cfg_data_i;
          CFG_HIGH_LIMIT: high_lim = cfg_data_i;
          CFG_DEADBAND: dead_band = cfg_data_i;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (level_words_q.size() == 0) begin
          $display("%0t unexpected result word: level %0d held %0d", $time,
                   out_mon.level, out_mon.held_level);
          fails++;
        end else begin
          want = level_words_q.pop_front();
          check_field("level", want.level, out_mon.level);
          check_field("held_level", want.held, out_mon.held_level);
          check_field("high_segments", DATA_W'(want.high_segs),
                      DATA_W'(out_mon.high_segments));
          check_field("low_segments", DATA_W'(want.low_segs),
                      DATA_W'(out_mon.low_segments));
          check_field("match", DATA_W'(want.match), DATA_W'(out_mon.match));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        sum_next = int'(run_sum) + int'(in_mon.sample);
        if (run_cnt == RUN_LENGTH - 1) begin
          avg = (sum_next / RUN_LENGTH) & 32'hFF;
          gap = (avg >= held_avg) ? avg - int'(held_avg) : int'(held_avg) - avg;
          if (gap > dead_band) held_avg = avg[DATA_W-1:0];
          if (held_avg <= low_lim) lvl = 0;
          else if (held_avg >= high_lim) lvl = 255;
          else lvl = ((int'(held_avg) - int'(low_lim)) * 255) /
                     (int'(high_lim) - int'(low_lim));
          want.level = lvl[7:0];
          want.held = held_avg;
          want.high_segs = DIGIT_SEGS[lvl[7:4]];
          want.low_segs = DIGIT_SEGS[lvl[3:0]];
          want.match = (lvl[7:0] == in_mon.compare_value);
          level_words_q.push_back(want);
          run_sum = '0;
          run_cnt = '0;
        end else begin
          run_sum = sum_next[SUM_W-1:0];
          run_cnt = run_cnt + 1'b1;
        end
      end
      pending_o <= level_words_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ tb/tb_adc_average_deadband_calibrate_unit.sv @@
// testbench top for adc_average_deadband_calibrate_unit: clock, reset, sample and register
// stimulus, random backpressure and the verdict; depends on adcal_pkg, the channel
// interfaces and adcal_level_checker
`timescale 1ns / 1ps

module tb_adc_average_deadband_calibrate_unit;
  import adcal_pkg::*;

  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 232;
  localparam int SETTLE_CYCLES = 40;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    RUN_FLAT,
    RUN_NOISY,
    RUN_WILD,
    RUN_RAIL
  } run_shape_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DATA_W-1:0]    cfg_data;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   fail_count;
  int                   pending;
  int                   run_pos;
  int                   run_base;
  run_shape_e           run_shape;

  adcal_in_if in_bus ();
  adcal_out_if out_bus ();

  adc_average_deadband_calibrate_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_bus),
    .out_if     (out_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  adcal_level_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic int clamp_byte(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic send_word(input logic [DATA_W-1:0] smp, input logic [DATA_W-1:0] cmpv);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.sample <= smp;
    in_bus.compare_value <= cmpv;
    do @(posedge clk_i); while (!in_bus.ready);
    run_pos = (run_pos + 1) % RUN_LENGTH;
  endtask

  task automatic send_random_word();
    int v;
    logic [DATA_W-1:0] cmpv;
    if (run_pos == 0) begin
      run_shape = run_shape_e'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) run_base = $urandom_range(0, 255);
      else run_base = clamp_byte(run_base + int'($urandom_range(0, 8)) - 4);
      if (run_shape == RUN_RAIL) run_base = $urandom_range(0, 1) ? 255 : 0;
    end
    case (run_shape)
      RUN_FLAT, RUN_RAIL: v = run_base;
      RUN_NOISY: v = clamp_byte(run_base + int'($urandom_range(0, 6)) - 3);
      default: v = $urandom_range(0, 255);
    endcase
    cmpv = DATA_W'($urandom_range(0, 255));
    if (run_pos == RUN_LENGTH - 1) begin
      case ($urandom_range(0, 2))
        0: cmpv = run_base[7:0];
        1: cmpv = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: ;
      endcase
    end
    send_word(v[7:0], cmpv);
  endtask

  // hold off until every result word is back, then let the block settle
  task automatic wait_for_idle();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
  endtask

  initial begin
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] db;
    rst_ni = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.sample = '0;
    in_bus.compare_value = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_LOW_LIMIT;
    cfg_data = '0;
    send_idle_pct = 25;
    recv_idle_pct = 65;
    run_pos = 0;
    run_base = 0;
    run_shape = RUN_WILD;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale run at reset settings, then the start of an all-zero run
    for (int i = 0; i < RUN_LENGTH; i++) begin
      send_word(8'hFF, (i == RUN_LENGTH - 1 || i % 2 == 0) ? 8'hFF : 8'h00);
    end
    for (int i = 0; i < 8; i++) begin
      send_word(8'h00, 8'h00);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_idle();
      case (phase)
        0: begin
          lo = LOW_LIMIT_RST;
          hi = HIGH_LIMIT_RST;
          db = DEADBAND_RST;
        end
        1: begin
          lo = 8'd0;
          hi = 8'd255;
          db = 8'd0;
        end
        2: begin
          lo = 8'd255;
          hi = 8'd0;
          db = 8'd255;
        end
        3: begin
          lo = 8'd128;
          hi = 8'd128;
          db = 8'd0;
        end
        4: begin
          lo = DATA_W'($urandom_range(0, 127));
          hi = DATA_W'($urandom_range(128, 255));
          db = DATA_W'($urandom_range(0, 7));
        end
        5: begin
          lo = DATA_W'($urandom_range(0, 255));
          hi = DATA_W'($urandom_range(0, 255));
          db = DATA_W'($urandom_range(0, 15));
        end
        default: begin
          lo = 8'd1;
          hi = 8'd254;
          db = 8'd1;
        end
      endcase
      write_reg(CFG_LOW_LIMIT, lo);
      write_reg(CFG_HIGH_LIMIT, hi);
      write_reg(CFG_DEADBAND, db);
      if (phase == 0) write_reg(CFG_UNUSED, DATA_W'($urandom_range(0, 255)));
      cfg_we <= 1'b0;
      if (phase < 3) begin
        send_idle_pct = 25;
        recv_idle_pct = 65;
      end else if (phase < 5) begin
        send_idle_pct = 65;
        recv_idle_pct = 25;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_random_word();
      end
    end

    wait_for_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ adc_average_deadband_calibrate_unit.f @@
rtl/adcal_pkg.sv
rtl/adcal_in_if.sv
rtl/adcal_out_if.sv
rtl/adcal_div.sv
rtl/adc_average_deadband_calibrate_unit.sv
rtl/adcal_chk.sv
tb/adcal_level_checker.sv
tb/tb_adc_average_deadband_calibrate_unit.sv
